### rtl/pbse_pkg.sv
// PackBits stream encoder: shared types and constants.
// Depends on nothing; imported by every module of the encoder.
package pbse_pkg;

    localparam int POS_BITS    = 32;
    localparam int MAX_RESULTS = 5;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] MAX_BLOCK    = 8'd128;
    localparam logic [7:0] END_MARKER   = 8'd128;
    localparam logic [8:0] RUN_HDR_BASE = 9'd257;
    localparam logic [7:0] RUN_START    = 8'd2;

    typedef logic [POS_BITS-1:0] pos_t;

    // one coded-byte write
    typedef struct packed {
        logic  done;
        logic [7:0] data;
        pos_t  pos;
    } res_t;

    // every write caused by one raw byte, lowest slot first
    typedef struct packed {
        logic [CNT_BITS-1:0]        count;
        res_t [MAX_RESULTS-1:0]     item;
    } res_set_t;

endpackage

### rtl/packbits_stream_encoder_top.sv
// PackBits stream encoder: top level with the byte input and coded-write output streams.
// Depends on pbse_pkg, pbse_step and pbse_result_buf.
//
// Usage
//   Slave stream: one raw byte per beat on s_tdata, s_tlast marks the final
//   byte of a stream. Master stream: one coded-byte write per beat, the
//   output offset and the byte on m_tdata, m_tlast set on the end marker.
//   Literal bytes go out as soon as they are known; a literal block header
//   is written into its reserved offset when the block closes, so writes
//   are not in address order and the receiver should store them by offset.
//   The first write of a byte is registered and appears in the cycle after the
//   beat is taken. Throughput: one output write per cycle while m_tready is
//   high; an input byte is held off until the writes of the previous byte are
//   all out, and a byte that brings no write, such as one that extends a run,
//   does not hold off the next byte.
//   Stall: while m_tready is low the pending write holds and, while a write is pending, s_tready stays low.
//   Reset: coding state returns to offset zero with no block open and the
//   result register empties; when the final byte is taken the coding state resets likewise.
module packbits_stream_encoder_top
    import pbse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] out_position, [39:32] out_byte
    output logic        m_tlast     // stream_done
);

    logic     in_fire;
    logic     buf_free;
    res_set_t set;
    res_t     head;

    // take a byte only when the result register will be drained by this edge
    assign s_tready = buf_free;
    assign in_fire  = s_tvalid && s_tready;

    pbse_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .in_byte    (s_tdata),
        .final_byte (s_tlast),
        .set        (set)
    );

    pbse_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_fire),
        .set        (set),
        .empty_soon (buf_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (head)
    );

    assign m_tdata = {head.data, head.pos};
    assign m_tlast = head.done;

endmodule

### rtl/pbse_step.sv
// PackBits stream encoder: coding state and the single-pass step logic.
// Depends on pbse_pkg; produces the full set of writes for each accepted byte.
module pbse_step
    import pbse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [7:0]  in_byte,
    input  logic        final_byte,
    output res_set_t    set
);

    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] run_length_reg, run_length_next;
    logic [7:0] literal_count_reg, literal_count_next;
    pos_t       slot_reg, slot_next;
    pos_t       wpos_reg, wpos_next;

    always_comb
    begin
        logic [7:0]          hb;
        logic                hv;
        logic [7:0]          rl;
        logic [7:0]          lc;
        pos_t                slot;
        pos_t                wp;
        logic [CNT_BITS-1:0] n;

        hb   = held_byte_reg;
        hv   = held_valid_reg;
        rl   = run_length_reg;
        lc   = literal_count_reg;
        slot = slot_reg;
        wp   = wpos_reg;
        n    = '0;
        set  = '0;

        if (rl != 8'd0)
        begin
            if (in_byte == hb && rl < MAX_BLOCK)
            begin
                rl = rl + 8'd1;
            end
            else
            begin
                // close the run: header then value
                set.item[n] = '{done: 1'b0, data: 8'(RUN_HDR_BASE - {1'b0, rl}), pos: wp};
                n  = n + 1'b1;
                wp = wp + 1'b1;
                set.item[n] = '{done: 1'b0, data: hb, pos: wp};
                n  = n + 1'b1;
                wp = wp + 1'b1;
                rl = 8'd0;
                hb = in_byte;
            end
        end
        else if (hv)
        begin
            if (in_byte == hb)
            begin
                if (lc != 8'd0)
                begin
                    set.item[n] = '{done: 1'b0, data: lc - 8'd1, pos: slot};
                    n  = n + 1'b1;
                    lc = 8'd0;
                end
                rl = RUN_START;
            end
            else
            begin
                // held byte joins the literal block
                if (lc == 8'd0)
                begin
                    slot = wp;
                    wp   = wp + 1'b1;
                end
                set.item[n] = '{done: 1'b0, data: hb, pos: wp};
                n  = n + 1'b1;
                wp = wp + 1'b1;
                lc = lc + 8'd1;
                if (lc >= MAX_BLOCK)
                begin
                    set.item[n] = '{done: 1'b0, data: lc - 8'd1, pos: slot};
                    n  = n + 1'b1;
                    lc = 8'd0;
                end
                hb = in_byte;
            end
        end
        else
        begin
            hb = in_byte;
            hv = 1'b1;
        end

        if (final_byte)
        begin
            if (rl != 8'd0)
            begin
                set.item[n] = '{done: 1'b0, data: 8'(RUN_HDR_BASE - {1'b0, rl}), pos: wp};
                n  = n + 1'b1;
                wp = wp + 1'b1;
                set.item[n] = '{done: 1'b0, data: hb, pos: wp};
                n  = n + 1'b1;
                wp = wp + 1'b1;
            end
            else if (hv)
            begin
                if (lc == 8'd0)
                begin
                    slot = wp;
                    wp   = wp + 1'b1;
                end
                set.item[n] = '{done: 1'b0, data: hb, pos: wp};
                n  = n + 1'b1;
                wp = wp + 1'b1;
                lc = lc + 8'd1;
                if (lc >= MAX_BLOCK)
                begin
                    set.item[n] = '{done: 1'b0, data: lc - 8'd1, pos: slot};
                    n  = n + 1'b1;
                    lc = 8'd0;
                end
            end
            if (lc != 8'd0)
            begin
                set.item[n] = '{done: 1'b0, data: lc - 8'd1, pos: slot};
                n  = n + 1'b1;
            end
            set.item[n] = '{done: 1'b1, data: END_MARKER, pos: wp};
            n = n + 1'b1;
            // stream ends: start the next one from scratch
            hb   = 8'd0;
            hv   = 1'b0;
            rl   = 8'd0;
            lc   = 8'd0;
            slot = '0;
            wp   = '0;
        end

        set.count          = n;
        held_byte_next     = hb;
        held_valid_next    = hv;
        run_length_next    = rl;
        literal_count_next = lc;
        slot_next          = slot;
        wpos_next          = wp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg     <= 8'd0;
            held_valid_reg    <= 1'b0;
            run_length_reg    <= 8'd0;
            literal_count_reg <= 8'd0;
            slot_reg          <= '0;
            wpos_reg          <= '0;
        end
        else if (fire)
        begin
            held_byte_reg     <= held_byte_next;
            held_valid_reg    <= held_valid_next;
            run_length_reg    <= run_length_next;
            literal_count_reg <= literal_count_next;
            slot_reg          <= slot_next;
            wpos_reg          <= wpos_next;
        end
    end

endmodule

### rtl/pbse_result_buf.sv
// PackBits stream encoder: result register file that hands out one write per beat.
// Depends on pbse_pkg; loaded with a whole result set, drained from slot zero.
module pbse_result_buf
    import pbse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  res_set_t set,
    output logic     empty_soon,
    output logic     out_valid,
    input  logic     out_ready,
    output res_t     out_item
);

    res_t [MAX_RESULTS-1:0] items_reg, items_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   pop;

    assign out_valid  = (cnt_reg != '0);
    assign pop        = out_valid && out_ready;
    // empty at the next edge, so a fresh set may be loaded now
    assign empty_soon = (cnt_reg == '0) || (cnt_reg == CNT_BITS'(1) && out_ready);
    assign out_item   = items_reg[0];

    always_comb
    begin
        items_next = items_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            items_next = set.item;
            cnt_next   = set.count;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                items_next[i] = items_reg[i+1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for packbits_stream_encoder_top: raw byte streams in, coded-byte writes out,
// each write checked against a predictor kept in a small scoreboard class.
// Depends on pbse_pkg and the encoder RTL only.
module testbench;
    import pbse_pkg::*;

    localparam int ITEM_TARGET = 410;
    localparam int IDLE_PCT    = 26;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    // one expected write to the coded output
    typedef struct packed {
        pos_t       pos;
        logic [7:0] data;
        logic       done;
    } coded_write_t;

    // Predicts the coded writes of each raw byte and checks the writes seen
    // on the master side against them, oldest first.
    class coded_write_board;
        logic [7:0]   held_byte;
        bit           held_valid;
        logic [7:0]   run_len;
        logic [7:0]   lit_count;
        pos_t         hdr_slot;
        pos_t         wr_pos;
        coded_write_t pending[$];
        int           errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            held_byte  = '0;
            held_valid = 1'b0;
            run_len    = '0;
            lit_count  = '0;
            hdr_slot   = '0;
            wr_pos     = '0;
        endfunction

        function void push(pos_t p, logic [7:0] d, logic done);
            coded_write_t w;
            w.pos  = p;
            w.data = d;
            w.done = done;
            pending.insert(pending.size(), w);
        endfunction

        function void push_next(logic [7:0] d);
            push(wr_pos, d, 1'b0);
            wr_pos++;
        endfunction

        // patch the header of the open literal block into its reserved slot
        function void close_literal();
            if (lit_count != 0)
            begin
                push(hdr_slot, lit_count - 8'd1, 1'b0);
                lit_count = '0;
            end
        endfunction

        function void put_literal(logic [7:0] b);
            if (lit_count == 0)
            begin
                hdr_slot = wr_pos;
                wr_pos++;
            end
            push_next(b);
            lit_count++;
            if (lit_count >= MAX_BLOCK)
                close_literal();
        endfunction

        function void close_run();
            logic [8:0] hdr;
            hdr = RUN_HDR_BASE - {1'b0, run_len};
            push_next(hdr[7:0]);
            push_next(held_byte);
            run_len = '0;
        endfunction

        function void note_raw_byte(logic [7:0] b, logic is_last);
            if (run_len != 0)
            begin
                // a run at its cap closes and the equal byte starts afresh
                if (b == held_byte && run_len < MAX_BLOCK)
                    run_len++;
                else
                begin
                    close_run();
                    held_byte = b;
                end
            end
            else if (held_valid)
            begin
                if (b == held_byte)
                begin
                    close_literal();
                    run_len = RUN_START;
                end
                else
                begin
                    put_literal(held_byte);
                    held_byte = b;
                end
            end
            else
            begin
                held_byte  = b;
                held_valid = 1'b1;
            end

            if (is_last)
            begin
                if (run_len != 0)
                    close_run();
                else if (held_valid)
                    put_literal(held_byte);
                close_literal();
                push(wr_pos, END_MARKER, 1'b1);
                clear_state();
            end
        endfunction

        function void check_coded_write(pos_t pos, logic [7:0] data, logic done);
            coded_write_t want;
            bit           bad;
            string        note;
            want = '{default: 'x};
            bad  = 1'b1;
            note = " (nothing expected)";
            if (pending.size() != 0)
            begin
                want = pending.pop_front();
                note = "";
                bad  = (pos !== want.pos) || (data !== want.data) || (done !== want.done);
            end
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                    $display({"write mismatch: expected pos %0d byte %02h done %0b, ",
                              "got pos %0d byte %02h done %0b%s"},
                             want.pos, want.data, want.done, pos, data, done, note);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;       // [7:0] in_byte
    logic        s_tlast;       // final_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;       // [31:0] out_position, [39:32] out_byte
    logic        m_tlast;       // stream_done

    coded_write_board board = new();
    logic [7:0]       raw_stream[$];
    int               bytes_sent = 0;
    int               cycles     = 0;
    logic             hold_off   = 1'b0;

    // a window of beats in which neither side idles
    wire steady = (bytes_sent >= 200) && (bytes_sent < 300);

    packbits_stream_encoder_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one byte, idling at random first, and hold it until the beat is taken.
    // Valid is left high so that a following byte goes out back to back.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_raw_byte(b, is_last);
        bytes_sent <= bytes_sent + 1;
    endtask

    // Send the queued stream, flagging its final byte, then empty the queue.
    task automatic send_stream();
        foreach (raw_stream[i])
            send_byte(raw_stream[i], i == raw_stream.size() - 1);
        raw_stream.delete();
    endtask

    // Drop valid and hold until every predicted write has arrived.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // Append one raw byte to the stream being built.
    task automatic append_raw(input logic [7:0] b);
        raw_stream.insert(raw_stream.size(), b);
    endtask

    task automatic add_run(input int n, input logic [7:0] v);
        repeat (n)
            append_raw(v);
    endtask

    // Append bytes that each differ from the byte before them.
    task automatic add_literal(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom);
            if (raw_stream.size() != 0 && b == raw_stream[$])
                b = b ^ 8'h5a;
            append_raw(b);
        end
    endtask

    // Mostly runs and literal blocks with random content, now and then one
    // near the block cap, and some noise from a tiny alphabet.
    task automatic build_random_stream();
        int segments;
        int kind;
        segments = $urandom_range(1, 6);
        repeat (segments)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 3)
                add_run($urandom_range(126, 258), 8'($urandom));
            else if (kind < 6)
                add_literal($urandom_range(126, 131));
            else if (kind < 40)
                add_run($urandom_range(1, 8), 8'($urandom));
            else if (kind < 75)
                add_literal($urandom_range(1, 8));
            else
                repeat ($urandom_range(1, 10))
                    append_raw(8'($urandom_range(0, 3)));
        end
    endtask

    // Receiver: check each accepted write, then pick the next ready level.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_coded_write(m_tdata[31:0], m_tdata[39:32], m_tlast);
            m_tready <= !hold_off && (steady || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Hold the receiver off for a long stretch while the sender keeps offering,
    // so the encoder fills up and stalls its input.
    initial
    begin
        wait (bytes_sent >= 60);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[packbits_stream_encoder_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        int streams;
        streams = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single byte, then a run of two that ends the stream
        raw_stream = '{8'h00};
        send_stream();
        raw_stream = '{8'hff, 8'hff};
        send_stream();
        // pure literal block over the byte extremes
        raw_stream = '{8'h00, 8'h55, 8'haa, 8'hff};
        send_stream();
        // held byte equal to the new one closes a literal, a new byte closes the run
        raw_stream = '{8'h12, 8'h34, 8'h34, 8'h34, 8'h56};
        send_stream();
        raw_stream = '{8'h80, 8'h7f, 8'h7f};
        send_stream();
        raw_stream = '{8'h01, 8'h01, 8'h02};
        send_stream();

        // run past its cap, then a literal block that reaches its cap
        add_run(130, 8'($urandom));
        add_literal(3);
        send_stream();
        add_literal(129);
        add_run(2, 8'($urandom));
        send_stream();

        while (bytes_sent < ITEM_TARGET)
        begin
            build_random_stream();
            send_stream();
            streams++;
            // pause once with nothing in flight
            if (streams == 1)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (20)
            @(posedge clk);
        if (board.errors == 0)
            $display("[packbits_stream_encoder_top] OK");
        else
            $display("[packbits_stream_encoder_top] ERROR");
        $finish;
    end

endmodule

### files.f
rtl/pbse_pkg.sv
rtl/pbse_step.sv
rtl/pbse_result_buf.sv
rtl/packbits_stream_encoder_top.sv
dv/testbench.sv
